// ----- hdl/dfe_pkg.sv -----
package dfe_pkg;

   // Field widths are fixed by the request format.
   localparam int DATA_BITS     = 16;
   localparam int COEF_BITS     = 16;
   localparam int INDEX_BITS    = 5;
   localparam int FEEDBACK_TAPS = 8;
   localparam int TAPS_DEFAULT  = 32;

   // Feedforward products are summed in groups of this size per pipeline stage.
   localparam int GROUP_SIZE    = 8;

   localparam int PRODUCT_BITS  = DATA_BITS + COEF_BITS;
   localparam int PRODUCT_SHIFT = COEF_BITS - 1;

   // func codes
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   typedef logic signed [DATA_BITS-1:0] data_type;
   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef logic [INDEX_BITS-1:0]       index_type;

   // Update to the tap state on an accepted request.
   typedef struct packed {
      logic      shift;
      logic      coef_we;
      index_type coef_index;
      coef_type  coef_value;
   } tap_write_type;

   // Per-stage load enables of the datapath pipeline.
   typedef struct packed {
      logic p_load;
      logic g_load;
      logic o_load;
   } pipe_ctrl_type;

   // Full product, floor-shifted by the coefficient fraction bits, wrapped to
   // the data width. Arithmetic right shift rounds toward minus infinity.
   function automatic data_type trunc_product(data_type d, coef_type c);
      logic signed [PRODUCT_BITS-1:0] p;
      p = PRODUCT_BITS'(d) * PRODUCT_BITS'(c);
      return p[PRODUCT_SHIFT +: DATA_BITS];
   endfunction

endpackage

// ----- hdl/dfe_req_if.sv -----
interface dfe_req_if;
   logic                valid;
   logic                ready;
   logic                func;
   dfe_pkg::index_type  coef_index;
   dfe_pkg::coef_type   coef_value;
   dfe_pkg::data_type   sample;
   dfe_pkg::data_type   decision_0;
   dfe_pkg::data_type   decision_1;
   dfe_pkg::data_type   decision_2;
   dfe_pkg::data_type   decision_3;
   dfe_pkg::data_type   decision_4;
   dfe_pkg::data_type   decision_5;
   dfe_pkg::data_type   decision_6;
   dfe_pkg::data_type   decision_7;

   modport source (
      output valid, func, coef_index, coef_value, sample,
             decision_0, decision_1, decision_2, decision_3,
             decision_4, decision_5, decision_6, decision_7,
      input  ready
   );

   modport sink (
      input  valid, func, coef_index, coef_value, sample,
             decision_0, decision_1, decision_2, decision_3,
             decision_4, decision_5, decision_6, decision_7,
      output ready
   );
endinterface

// ----- hdl/dfe_rsp_if.sv -----
interface dfe_rsp_if;
   logic              valid;
   logic              ready;
   dfe_pkg::data_type equalized;

   modport source (output valid, equalized, input ready);
   modport sink   (input valid, equalized, output ready);
endinterface

// ----- hdl/dfe_tap_state.sv -----
module dfe_tap_state #(
   parameter int TAPS = dfe_pkg::TAPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dfe_pkg::tap_write_type wr,
   input  dfe_pkg::data_type     sample,
   output dfe_pkg::data_type     taps [TAPS],
   output dfe_pkg::coef_type     coefs [TAPS]
);

   dfe_pkg::data_type hist_ff [TAPS];
   dfe_pkg::data_type hist_in [TAPS];
   dfe_pkg::coef_type coef_ff [TAPS];
   dfe_pkg::coef_type coef_in [TAPS];

   // History as it stands once the new sample has shifted in.
   always_comb begin
      taps[0] = sample;
      for (int i = 1; i < TAPS; i++) begin
         taps[i] = hist_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         hist_in[i] = wr.shift ? taps[i] : hist_ff[i];
         coef_in[i] = coef_ff[i];
         // slots at or beyond TAPS never match, so such loads are dropped
         if (wr.coef_we && (32'(wr.coef_index) == i)) begin
            coef_in[i] = wr.coef_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TAPS; i++) begin
         if (reset) begin
            hist_ff[i] <= '0;
            coef_ff[i] <= '0;
         end else begin
            hist_ff[i] <= hist_in[i];
            coef_ff[i] <= coef_in[i];
         end
      end
   end

   assign coefs = coef_ff;

endmodule

// ----- hdl/dfe_products.sv -----
module dfe_products #(
   parameter int TAPS = dfe_pkg::TAPS_DEFAULT
) (
   input  logic                  clock,
   input  dfe_pkg::pipe_ctrl_type ctrl,
   input  dfe_pkg::data_type     taps [TAPS],
   input  dfe_pkg::coef_type     coefs [TAPS],
   input  dfe_pkg::data_type     decisions [dfe_pkg::FEEDBACK_TAPS],
   output dfe_pkg::data_type     ff_prod [TAPS],
   output dfe_pkg::data_type     fb_prod [dfe_pkg::FEEDBACK_TAPS]
);

   dfe_pkg::data_type ff_prod_ff [TAPS];
   dfe_pkg::data_type fb_prod_ff [dfe_pkg::FEEDBACK_TAPS];
   dfe_pkg::data_type ff_prod_in [TAPS];
   dfe_pkg::data_type fb_prod_in [dfe_pkg::FEEDBACK_TAPS];

   // One multiplier per lane.
   for (genvar i = 0; i < TAPS; i++) begin : g_ff
      assign ff_prod_in[i] = dfe_pkg::trunc_product(taps[i], coefs[i]);
   end

   // Feedback taps past the end of the table weigh with zero.
   for (genvar i = 0; i < dfe_pkg::FEEDBACK_TAPS; i++) begin : g_fb
      if (i < TAPS) begin : g_used
         assign fb_prod_in[i] = dfe_pkg::trunc_product(decisions[i], coefs[i]);
      end else begin : g_zero
         assign fb_prod_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.p_load) begin
         ff_prod_ff <= ff_prod_in;
         fb_prod_ff <= fb_prod_in;
      end
   end

   assign ff_prod = ff_prod_ff;
   assign fb_prod = fb_prod_ff;

endmodule

// ----- hdl/dfe_sum.sv -----
module dfe_sum #(
   parameter int TAPS = dfe_pkg::TAPS_DEFAULT
) (
   input  logic                  clock,
   input  dfe_pkg::pipe_ctrl_type ctrl,
   input  dfe_pkg::data_type     ff_prod [TAPS],
   input  dfe_pkg::data_type     fb_prod [dfe_pkg::FEEDBACK_TAPS],
   output dfe_pkg::data_type     equalized
);

   localparam int NGROUPS = (TAPS + dfe_pkg::GROUP_SIZE - 1) / dfe_pkg::GROUP_SIZE;

   dfe_pkg::data_type group_ff [NGROUPS];
   dfe_pkg::data_type group_in [NGROUPS];
   dfe_pkg::data_type fb_sum_ff;
   dfe_pkg::data_type fb_sum_in;
   dfe_pkg::data_type eq_ff;
   dfe_pkg::data_type eq_in;

   // Partial sums, all wrapping at the data width.
   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < dfe_pkg::GROUP_SIZE; k++) begin
            if (g * dfe_pkg::GROUP_SIZE + k < TAPS) begin
               group_in[g] = group_in[g] + ff_prod[g * dfe_pkg::GROUP_SIZE + k];
            end
         end
      end
   end

   always_comb begin
      fb_sum_in = '0;
      for (int i = 0; i < dfe_pkg::FEEDBACK_TAPS; i++) begin
         fb_sum_in = fb_sum_in + fb_prod[i];
      end
   end

   always_comb begin
      eq_in = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         eq_in = eq_in + group_ff[g];
      end
      eq_in = eq_in - fb_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.g_load) begin
         group_ff  <= group_in;
         fb_sum_ff <= fb_sum_in;
      end
      if (ctrl.o_load) begin
         eq_ff <= eq_in;
      end
   end

   assign equalized = eq_ff;

endmodule

// ----- hdl/decision_feedback_equalizer.sv -----
// Throughput: one request per cycle while req.ready is high (no back-pressure);
// a load request is done at its own accept edge.
// Stages: product register, group-sum register, result register; each holds under
// back-pressure and takes a new item as soon as the stage after it moves on.
// Reset (synchronous, active high): clears sample history, coefficients and all
// pipeline valid flags; req.ready is high again in the cycle after reset.
module decision_feedback_equalizer #(
   parameter int TAPS = dfe_pkg::TAPS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   dfe_req_if.sink   req,
   dfe_rsp_if.source rsp
);

   // ---------------------------------------------------------------------
   // Pipeline flow control
   // A stage may load when it is empty or when its content moves on in the
   // same cycle. The chain ends at the result register, so a waiting result
   // only blocks the stages once they have all filled up behind it.
   // ---------------------------------------------------------------------
   logic p_valid_ff, p_valid_in;
   logic g_valid_ff, g_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, g_free, p_free;
   logic accept, sample_acc, load_acc;

   dfe_pkg::pipe_ctrl_type ctrl;
   dfe_pkg::tap_write_type wr;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign g_free   = !g_valid_ff || out_free;
   assign p_free   = !p_valid_ff || g_free;

   assign req.ready  = p_free;
   assign accept     = req.valid && p_free;
   assign sample_acc = accept && (req.func == dfe_pkg::FUNC_SAMPLE);
   assign load_acc   = accept && (req.func == dfe_pkg::FUNC_LOAD);

   assign ctrl.p_load = p_free;
   assign ctrl.g_load = g_free;
   assign ctrl.o_load = out_free;

   assign p_valid_in   = p_free   ? sample_acc : p_valid_ff;
   assign g_valid_in   = g_free   ? p_valid_ff : g_valid_ff;
   assign rsp_valid_in = out_free ? g_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         g_valid_ff   <= g_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Tap state: history shift on a sample request, coefficient write on a
   // load request. Both take effect at the accept edge, so the products of
   // a sample see every load request that came before it and none after.
   // ---------------------------------------------------------------------
   assign wr.shift      = sample_acc;
   assign wr.coef_we    = load_acc;
   assign wr.coef_index = req.coef_index;
   assign wr.coef_value = req.coef_value;

   dfe_pkg::data_type taps  [TAPS];
   dfe_pkg::coef_type coefs [TAPS];

   dfe_tap_state #(.TAPS(TAPS)) u_tap_state (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .sample (req.sample),
      .taps   (taps),
      .coefs  (coefs)
   );

   // ---------------------------------------------------------------------
   // Products: captured at the accept edge of the sample request.
   // ---------------------------------------------------------------------
   dfe_pkg::data_type decisions [dfe_pkg::FEEDBACK_TAPS];
   dfe_pkg::data_type ff_prod   [TAPS];
   dfe_pkg::data_type fb_prod   [dfe_pkg::FEEDBACK_TAPS];

   assign decisions[0] = req.decision_0;
   assign decisions[1] = req.decision_1;
   assign decisions[2] = req.decision_2;
   assign decisions[3] = req.decision_3;
   assign decisions[4] = req.decision_4;
   assign decisions[5] = req.decision_5;
   assign decisions[6] = req.decision_6;
   assign decisions[7] = req.decision_7;

   dfe_products #(.TAPS(TAPS)) u_products (
      .clock     (clock),
      .ctrl      (ctrl),
      .taps      (taps),
      .coefs     (coefs),
      .decisions (decisions),
      .ff_prod   (ff_prod),
      .fb_prod   (fb_prod)
   );

   // ---------------------------------------------------------------------
   // Group sums, then feedforward total minus feedback into the result reg.
   // ---------------------------------------------------------------------
   dfe_sum #(.TAPS(TAPS)) u_sum (
      .clock     (clock),
      .ctrl      (ctrl),
      .ff_prod   (ff_prod),
      .fb_prod   (fb_prod),
      .equalized (rsp.equalized)
   );

endmodule

// ----- hdl/dfe_checker.sv -----
module dfe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_func,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dfe_pkg::data_type rsp_equalized
);

   // no response straight out of reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // with the result register empty the whole pipe is free
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // an accepted sample request is later seen as a valid response
   a_sample_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == dfe_pkg::FUNC_SAMPLE)) |-> ##3 rsp_valid)
      else $error("sample request lost");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_equalized)))
      else $error("stalled response changed");

endmodule

bind decision_feedback_equalizer dfe_checker u_dfe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_func      (req.func),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_equalized (rsp.equalized)
);
